### design/a85_pkg.sv
// shared types, constants and helper function of the ascii85 string decoder
// no dependencies
`default_nettype none

package a85_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [7:0] CH_FIRST = 8'h21;
  localparam logic [7:0] CH_LAST  = 8'h75;
  localparam logic [7:0] CH_ZERO  = 8'h7a;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_GT    = 8'h3e;

  localparam logic [31:0] RADIX = 32'd85;

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_END  = 2'd1,
    TAIL_ERR  = 2'd2
  } tail_t;

  // one queued job: nbytes data bytes of value, msb first, then the tail result unless tail is TAIL_NONE
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  nbytes;
    tail_t       tail;
  } entry_t;

  // 85 ** (5 - cnt) for the padding of a partial group
  function automatic logic [19:0] pad_mul(input logic [2:0] cnt);
    logic [19:0] m;
    begin
      unique case (cnt)
        3'd2:    m = 20'd614125;
        3'd3:    m = 20'd7225;
        3'd4:    m = 20'd85;
        default: m = 20'd1;
      endcase
      return m;
    end
  endfunction

endpackage

`default_nettype wire

### design/a85_front.sv
// front end: accepts input bytes, keeps the group accumulator and builds jobs
// depends on a85_pkg
`default_nettype none

module a85_front
  import a85_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc_en,
  input  wire logic [7:0] in_byte,
  output logic            push,
  output entry_t          push_entry
);

  logic [31:0] group_r, group_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        tilde_r, tilde_nxt;

  logic [31:0] acc_val;
  logic [31:0] pad_val;
  logic [19:0] pmul;
  logic [6:0]  digit;

  always_comb begin
    digit   = 7'(in_byte - CH_FIRST);
    acc_val = group_r * RADIX + {25'd0, digit};
    pmul    = pad_mul(cnt_r);
    pad_val = group_r * {12'd0, pmul} + {12'd0, pmul} - 32'd1;
  end

  always_comb begin
    group_nxt         = group_r;
    cnt_nxt           = cnt_r;
    tilde_nxt         = tilde_r;
    push              = 1'b0;
    push_entry.value  = 32'd0;
    push_entry.nbytes = 3'd0;
    push_entry.tail   = TAIL_ERR;
    if (acc_en) begin
      if (tilde_r) begin
        push      = 1'b1;
        group_nxt = 32'd0;
        cnt_nxt   = 3'd0;
        tilde_nxt = 1'b0;
        if (in_byte == CH_GT && cnt_r != 3'd1) begin
          push_entry.tail = TAIL_END;
          if (cnt_r >= 3'd2) begin
            push_entry.value  = pad_val;
            push_entry.nbytes = cnt_r - 3'd1;
          end
        end
      end else if (in_byte == CH_TILDE) begin
        tilde_nxt = 1'b1;
      end else if (in_byte == CH_ZERO) begin
        push = 1'b1;
        if (cnt_r == 3'd0) begin
          push_entry.nbytes = 3'd4;
          push_entry.tail   = TAIL_NONE;
        end else begin
          group_nxt = 32'd0;
          cnt_nxt   = 3'd0;
        end
      end else if (in_byte < CH_FIRST || in_byte > CH_LAST) begin
        push      = 1'b1;
        group_nxt = 32'd0;
        cnt_nxt   = 3'd0;
      end else if (cnt_r == 3'd4) begin
        push              = 1'b1;
        push_entry.value  = acc_val;
        push_entry.nbytes = 3'd4;
        push_entry.tail   = TAIL_NONE;
        group_nxt         = 32'd0;
        cnt_nxt           = 3'd0;
      end else begin
        group_nxt = acc_val;
        cnt_nxt   = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= 32'd0;
      cnt_r   <= 3'd0;
      tilde_r <= 1'b0;
    end else begin
      group_r <= group_nxt;
      cnt_r   <= cnt_nxt;
      tilde_r <= tilde_nxt;
    end
  end

endmodule

`default_nettype wire

### design/a85_fifo.sv
// short job queue between the front end and the output sequencer
// depends on a85_pkg
`default_nettype none

module a85_fifo
  import a85_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        full,
  output logic        head_valid,
  output entry_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  entry_t          slots_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_MAX);
  assign head_valid = (cnt_r != '0);
  assign head       = slots_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_MAX) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_MAX) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### design/a85_back.sv
// output sequencer: expands queued jobs into result items through an output register
// depends on a85_pkg
`default_nettype none

module a85_back
  import a85_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   head_valid,
  input  wire entry_t head,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [1:0] kind_r;
  logic [7:0] byte_r;
  logic       last_r;

  logic       load;
  logic [1:0] res_kind;
  logic [7:0] res_byte;
  logic       res_last;

  always_comb begin
    res_kind = KIND_DATA;
    res_byte = 8'd0;
    res_last = 1'b1;
    if (idx_r < head.nbytes) begin
      case (idx_r[1:0])
        2'd0:    res_byte = head.value[31:24];
        2'd1:    res_byte = head.value[23:16];
        2'd2:    res_byte = head.value[15:8];
        default: res_byte = head.value[7:0];
      endcase
      res_last = (idx_r == head.nbytes - 3'd1) && (head.tail == TAIL_NONE);
    end else begin
      res_kind = (head.tail == TAIL_END) ? KIND_END : KIND_ERR;
    end
  end

  always_comb begin
    load      = head_valid && (!valid_r || !out_stall);
    pop       = load && res_last;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = res_last ? 3'd0 : idx_r + 3'd1;
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= res_kind;
      byte_r <= res_byte;
      last_r <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

### design/ascii85_string_decoder.sv
// top level of the ascii85 string decoder
// depends on a85_pkg, a85_front, a85_fifo, a85_back
`default_nettype none

// Decodes an ascii85 string body one byte per cycle. The front end takes an
// item in every cycle while the job queue has room; it does the base-85
// accumulate (and the padding multiply on '~>') in that same cycle and queues
// a job. The output sequencer sends one result item per cycle while out_stall
// is low, from a registered output; a steady run of five-digit groups
// sustains one input item per cycle when the output is not stalled, and
// bursts of 'z' (four results each) are held back by the QUEUE_DEPTH-entry
// queue, after which input is taken only as the sequencer frees queue entries.
// A result reaches the output through the queue and then the output register. No clearing pass.

module ascii85_string_decoder
  import a85_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic   full;
  logic   acc_en;
  logic   push;
  logic   pop;
  logic   head_valid;
  entry_t push_entry;
  entry_t head;

  assign in_stall = full;
  assign acc_en   = in_valid && !full;

  a85_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_en     (acc_en),
    .in_byte    (in_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  a85_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  a85_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

### design/a85_checker.sv
// port-level checks on the ascii85 string decoder, bound to its top level
// depends on a85_pkg and ascii85_string_decoder
`default_nettype none

module a85_checker
  import a85_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_byte))
    else $error("stalled item changed");

  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_last)
    else $error("end or error item not marked last");

  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_byte == 8'd0)
    else $error("end or error item carries a byte");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("item shown right after reset");

endmodule

bind ascii85_string_decoder a85_checker u_a85_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_kind  (out_kind),
  .out_byte  (out_byte),
  .out_last  (out_last)
);

`default_nettype wire
